// ===== sv/omsf_pkg.sv =====
// Shared types and constants for the occlusion merge/split lifecycle tracker.
// No dependencies; every other source file uses this package.
package omsf_pkg;

  // Default counter widths handed to the top-level parameters
  localparam int unsigned MERGED_COUNT_BITS_DEF = 16;
  localparam int unsigned STABLE_COUNT_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned STABLE_W    = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Person count thresholds
  localparam logic [COUNT_W-1:0] SINGLE_PERSON = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] GROUP_MIN     = COUNT_W'(2);

  // Lifecycle mode
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_MERGED = 2'd1,
    MODE_SPLIT  = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLAP_REQ  = 2'd0,
    CFG_MERGE_HOLD   = 2'd1,
    CFG_SPLIT_STABLE = 2'd2
  } cfg_idx_e;

  // Configuration seen by the tracking logic
  typedef struct packed {
    logic                overlap_req;
    logic [HOLD_W-1:0]   merge_hold;
    logic [STABLE_W-1:0] split_stable;
  } cfg_t;

endpackage

// ===== sv/omsf_if.sv =====
// Handshake channel interfaces: frame input, result output, config write.
// Depends on omsf_pkg for field widths.
interface omsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [omsf_pkg::COUNT_W-1:0] person_count;
  logic                        overlap_seen;

  modport source (output valid, output person_count, output overlap_seen, input ready);
  modport sink   (input valid, input person_count, input overlap_seen, output ready);
endinterface

interface omsf_out_if #(
  parameter int unsigned MERGED_COUNT_BITS = omsf_pkg::MERGED_COUNT_BITS_DEF,
  parameter int unsigned STABLE_COUNT_BITS = omsf_pkg::STABLE_COUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [omsf_pkg::MODE_W-1:0] lifecycle_mode;
  logic [MERGED_COUNT_BITS-1:0] merged_frame_count;
  logic [STABLE_COUNT_BITS-1:0] stable_split_count;
  logic                        features_frozen;

  modport source (output valid, output lifecycle_mode, output merged_frame_count,
                  output stable_split_count, output features_frozen, input ready);
  modport sink   (input valid, input lifecycle_mode, input merged_frame_count,
                  input stable_split_count, input features_frozen, output ready);
endinterface

interface omsf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [omsf_pkg::CFG_IDX_W-1:0]  index;
  logic [omsf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/omsf_cfg_regs.sv =====
// Configuration register file: overlap requirement, merge hold, split stable count.
// Depends on omsf_pkg and omsf_cfg_if.
module omsf_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  omsf_cfg_if.sink         cfg_i,
  output omsf_pkg::cfg_t   cfg_o
);
  import omsf_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Always take a write beat
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Decode the register index; unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_OVERLAP_REQ:  cfg_d.overlap_req  = cfg_i.data[0];
        CFG_MERGE_HOLD:   cfg_d.merge_hold   = cfg_i.data[HOLD_W-1:0];
        CFG_SPLIT_STABLE: cfg_d.split_stable = cfg_i.data[STABLE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overlap_req  <= 1'b1;
      cfg_q.merge_hold   <= HOLD_W'(1);
      cfg_q.split_stable <= STABLE_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/omsf_track.sv =====
// Lifecycle state machine: mode, saturating counters and last-frame history.
// Depends on omsf_pkg; driven by the top level one frame per advance.
module omsf_track #(
  parameter int unsigned MERGED_COUNT_BITS = omsf_pkg::MERGED_COUNT_BITS_DEF,
  parameter int unsigned STABLE_COUNT_BITS = omsf_pkg::STABLE_COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [omsf_pkg::COUNT_W-1:0]  person_count_i,
  input  logic                          overlap_seen_i,
  input  omsf_pkg::cfg_t                cfg_i,
  output omsf_pkg::mode_e               mode_o,
  output logic [MERGED_COUNT_BITS-1:0]  merged_cnt_o,
  output logic [STABLE_COUNT_BITS-1:0]  split_cnt_o,
  output logic                          frozen_o
);
  import omsf_pkg::*;

  localparam int unsigned HOLD_CMP_W = (MERGED_COUNT_BITS > HOLD_W) ? MERGED_COUNT_BITS : HOLD_W;
  localparam int unsigned NEED_CMP_W = (STABLE_COUNT_BITS > STABLE_W) ? STABLE_COUNT_BITS : STABLE_W;

  mode_e                        mode_q, mode_d;
  logic [MERGED_COUNT_BITS-1:0] merged_q, merged_d, merged_inc;
  logic [STABLE_COUNT_BITS-1:0] split_q, split_d, split_inc;
  logic [COUNT_W-1:0]           last_cnt_q;
  logic                         last_ovl_q;

  logic                evidence, stable, group_now, prior_ok, merged_or_split;
  logic [HOLD_W-1:0]   hold;
  logic [STABLE_W-1:0] need;

  // Frame qualifiers
  assign evidence  = !cfg_i.overlap_req || overlap_seen_i || last_ovl_q;
  assign group_now = (person_count_i >= GROUP_MIN);
  assign stable    = group_now && !overlap_seen_i;
  assign hold      = (cfg_i.merge_hold == '0) ? HOLD_W'(1) : cfg_i.merge_hold;
  assign need      = (cfg_i.split_stable == '0) ? STABLE_W'(1) : cfg_i.split_stable;

  // Saturating increments
  assign merged_inc = (merged_q == '1) ? merged_q : merged_q + MERGED_COUNT_BITS'(1);
  assign split_inc  = (split_q == '1) ? split_q : split_q + STABLE_COUNT_BITS'(1);

  always_comb begin
    unique case (mode_q)
      MODE_MERGED, MODE_SPLIT: merged_or_split = 1'b1;
      default:                 merged_or_split = 1'b0;
    endcase
  end
  assign prior_ok = (last_cnt_q >= GROUP_MIN) || merged_or_split;

  // Next state and counters, in priority order
  always_comb begin
    mode_d   = mode_q;
    merged_d = merged_q;
    split_d  = split_q;
    priority if ((person_count_i == SINGLE_PERSON) && evidence && prior_ok) begin
      mode_d   = MODE_MERGED;
      merged_d = merged_inc;
      split_d  = '0;
    end else if ((mode_q == MODE_MERGED) && group_now &&
                 (HOLD_CMP_W'(merged_q) >= HOLD_CMP_W'(hold))) begin
      mode_d  = MODE_SPLIT;
      split_d = '0;
    end else if (mode_q == MODE_SPLIT) begin
      if (stable) begin
        if (NEED_CMP_W'(split_inc) >= NEED_CMP_W'(need)) begin
          // Resume: collapse straight back to normal
          mode_d   = MODE_NORMAL;
          merged_d = '0;
          split_d  = '0;
        end else begin
          split_d = split_inc;
        end
      end else begin
        split_d = '0;
      end
    end else if (stable) begin
      mode_d   = MODE_NORMAL;
      merged_d = '0;
      split_d  = '0;
    end
  end

  // Result outputs from the next state
  always_comb begin
    mode_o       = mode_d;
    merged_cnt_o = merged_d;
    split_cnt_o  = split_d;
    unique case (mode_d)
      MODE_MERGED, MODE_SPLIT: frozen_o = 1'b1;
      default:                 frozen_o = overlap_seen_i;
    endcase
  end

  // Advance state on each frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      merged_q   <= '0;
      split_q    <= '0;
      last_cnt_q <= '0;
      last_ovl_q <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      merged_q   <= merged_d;
      split_q    <= split_d;
      last_cnt_q <= person_count_i;
      last_ovl_q <= overlap_seen_i;
    end
  end

endmodule

// ===== sv/occlusion_merge_split_fsm.sv =====
// Occlusion merge/split lifecycle tracker, top level.
// Depends on omsf_pkg, omsf_if, omsf_cfg_regs and omsf_track.
//
// Takes one frame beat per clock and returns one result beat per frame: the
// frame lands in an input register, the mode and counter update runs
// combinationally from there into the result register, and the state
// registers advance on that same edge, so a new frame is taken every
// cycle while the result side keeps up. Input ready drops only when both the
// input and result registers are full and the result beat is stalled.
// Configuration writes are taken at any time and should be issued while no
// frame is in flight; flags and state are reset, payload registers are not.
module occlusion_merge_split_fsm #(
  parameter int unsigned MERGED_COUNT_BITS = omsf_pkg::MERGED_COUNT_BITS_DEF,
  parameter int unsigned STABLE_COUNT_BITS = omsf_pkg::STABLE_COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  omsf_in_if.sink    frame_i,
  omsf_cfg_if.sink   cfg_i,
  omsf_out_if.source result_o
);
  import omsf_pkg::*;

  cfg_t cfg;

  logic               in_vld_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               ovl_q;
  logic               res_vld_q;
  logic               advance, in_take;

  mode_e                        mode_n;
  logic [MERGED_COUNT_BITS-1:0] merged_n;
  logic [STABLE_COUNT_BITS-1:0] split_n;
  logic                         frozen_n;

  logic [MODE_W-1:0]            mode_q;
  logic [MERGED_COUNT_BITS-1:0] merged_q;
  logic [STABLE_COUNT_BITS-1:0] split_q;
  logic                         frozen_q;

  omsf_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: advance when the result register is free or being drained
  assign advance       = in_vld_q && (!res_vld_q || result_o.ready);
  assign frame_i.ready = !in_vld_q || advance;
  assign in_take       = frame_i.valid && frame_i.ready;

  omsf_track #(
    .MERGED_COUNT_BITS (MERGED_COUNT_BITS),
    .STABLE_COUNT_BITS (STABLE_COUNT_BITS)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .person_count_i (cnt_q),
    .overlap_seen_i (ovl_q),
    .cfg_i          (cfg),
    .mode_o         (mode_n),
    .merged_cnt_o   (merged_n),
    .split_cnt_o    (split_n),
    .frozen_o       (frozen_n)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cnt_q <= frame_i.person_count;
      ovl_q <= frame_i.overlap_seen;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q   <= mode_n;
      merged_q <= merged_n;
      split_q  <= split_n;
      frozen_q <= frozen_n;
    end
  end

  assign result_o.valid              = res_vld_q;
  assign result_o.lifecycle_mode     = mode_q;
  assign result_o.merged_frame_count = merged_q;
  assign result_o.stable_split_count = split_q;
  assign result_o.features_frozen    = frozen_q;

endmodule

// ===== sv/omsf_checker.sv =====
// Port-level checks for the lifecycle tracker, bound to the top level.
// Depends on omsf_pkg and occlusion_merge_split_fsm.
module omsf_checker #(
  parameter int unsigned MERGED_COUNT_BITS = omsf_pkg::MERGED_COUNT_BITS_DEF,
  parameter int unsigned STABLE_COUNT_BITS = omsf_pkg::STABLE_COUNT_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic [omsf_pkg::MODE_W-1:0]        res_mode,
  input logic [MERGED_COUNT_BITS-1:0]       res_merged,
  input logic [STABLE_COUNT_BITS-1:0]       res_split,
  input logic                               res_frozen
);
  import omsf_pkg::*;

  // Stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_mode) && $stable(res_merged)
      && $stable(res_split) && $stable(res_frozen))
    else $error("result beat changed while stalled");

  // Any mode other than normal freezes features
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_mode != MODE_NORMAL) |-> res_frozen)
    else $error("features not frozen outside normal mode");

  // Normal mode always carries cleared counters
  a_normal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_mode == MODE_NORMAL) |-> (res_merged == '0) && (res_split == '0))
    else $error("counters not cleared in normal mode");

  // Merged mode has counted at least one frame and no recovery progress
  a_merged_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_mode == MODE_MERGED) |-> (res_merged != '0) && (res_split == '0))
    else $error("inconsistent counters in merged mode");

endmodule

bind occlusion_merge_split_fsm omsf_checker #(
  .MERGED_COUNT_BITS (MERGED_COUNT_BITS),
  .STABLE_COUNT_BITS (STABLE_COUNT_BITS)
) u_omsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (result_o.valid),
  .res_ready  (result_o.ready),
  .res_mode   (result_o.lifecycle_mode),
  .res_merged (result_o.merged_frame_count),
  .res_split  (result_o.stable_split_count),
  .res_frozen (result_o.features_frozen)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for occlusion_merge_split_fsm: frame beats in, lifecycle results out.
// Depends on omsf_pkg, omsf_if and the RTL; a local tracker predicts all but typed-row results.
`timescale 1ns / 100ps

module tb_top;
  import omsf_pkg::*;

  localparam int MW = MERGED_COUNT_BITS_DEF;
  localparam int SW = STABLE_COUNT_BITS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_FRAMES = 110;
  localparam int HOLD_RUN = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    mode_e         mode;
    logic [MW-1:0] merged;
    logic [SW-1:0] split;
    logic          frozen;
  } frame_result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               ovl;
    logic               typed;
    frame_result_t      want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  omsf_in_if  frame_if ();
  omsf_cfg_if cfg_if ();
  omsf_out_if res_if ();

  occlusion_merge_split_fsm uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  // Tracker state and its copy of the registers
  mode_e              trk_mode;
  logic [MW-1:0]      trk_merged;
  logic [SW-1:0]      trk_split;
  logic [COUNT_W-1:0] trk_last_cnt;
  logic               trk_last_ovl;
  logic               cfg_ovl_req;
  logic [HOLD_W-1:0]  cfg_hold;
  logic [STABLE_W-1:0] cfg_stable;

  frame_result_t due_results[$];
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   in_calm;
  int unsigned   out_calm;
  logic          no_idle;

  // Directed frames, run with the reset configuration
  stim_row_t directed_rows [19] = '{
    '{4'd0,  1'b0, 1'b1, '{MODE_NORMAL, 16'd0, 8'd0, 1'b0}},
    '{4'd15, 1'b1, 1'b1, '{MODE_NORMAL, 16'd0, 8'd0, 1'b1}},
    '{4'd1,  1'b0, 1'b1, '{MODE_MERGED, 16'd1, 8'd0, 1'b1}},
    '{4'd2,  1'b0, 1'b1, '{MODE_SPLIT,  16'd1, 8'd0, 1'b1}},
    '{4'd3,  1'b0, 1'b1, '{MODE_NORMAL, 16'd0, 8'd0, 1'b0}},
    '{4'd2,  1'b1, 1'b0, '0},
    '{4'd1,  1'b1, 1'b0, '0},
    '{4'd1,  1'b0, 1'b0, '0},
    '{4'd1,  1'b0, 1'b0, '0},
    '{4'd0,  1'b0, 1'b0, '0},
    '{4'd4,  1'b1, 1'b0, '0},
    '{4'd4,  1'b1, 1'b0, '0},
    '{4'd1,  1'b1, 1'b0, '0},
    '{4'd8,  1'b0, 1'b0, '0},
    '{4'd1,  1'b0, 1'b0, '0},
    '{4'd9,  1'b0, 1'b0, '0},
    '{4'd1,  1'b1, 1'b0, '0},
    '{4'd10, 1'b0, 1'b0, '0},
    '{4'd7,  1'b0, 1'b0, '0}
  };

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Wait length for one beat; calm stretches and the long merged run force zero
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (no_idle) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic void reset_tracker();
    trk_mode     = MODE_NORMAL;
    trk_merged   = '0;
    trk_split    = '0;
    trk_last_cnt = '0;
    trk_last_ovl = 1'b0;
    cfg_ovl_req  = 1'b1;
    cfg_hold     = HOLD_W'(1);
    cfg_stable   = STABLE_W'(1);
  endfunction

  // Advance the lifecycle tracker by one frame and return its result
  function automatic frame_result_t track_frame(input logic [COUNT_W-1:0] cnt, input logic ovl);
    frame_result_t       res;
    mode_e               prior;
    logic                evidence;
    logic                stable;
    logic [HOLD_W-1:0]   hold_eff;
    logic [STABLE_W-1:0] need_eff;
    prior    = trk_mode;
    evidence = !cfg_ovl_req || ovl || trk_last_ovl;
    stable   = (cnt >= GROUP_MIN) && !ovl;
    hold_eff = (cfg_hold == '0) ? HOLD_W'(1) : cfg_hold;
    need_eff = (cfg_stable == '0) ? STABLE_W'(1) : cfg_stable;
    if (cnt == SINGLE_PERSON && evidence &&
        (trk_last_cnt >= GROUP_MIN || prior == MODE_MERGED || prior == MODE_SPLIT)) begin
      trk_mode = MODE_MERGED;
      if (trk_merged != '1) trk_merged = trk_merged + 1'b1;
      trk_split = '0;
    end else if (prior == MODE_MERGED && cnt >= GROUP_MIN && trk_merged >= hold_eff) begin
      trk_mode  = MODE_SPLIT;
      trk_split = '0;
    end else if (prior == MODE_SPLIT) begin
      if (stable) begin
        if (trk_split != '1) trk_split = trk_split + 1'b1;
        // resumed collapses straight into normal
        if (trk_split >= need_eff) begin
          trk_mode   = MODE_NORMAL;
          trk_merged = '0;
          trk_split  = '0;
        end
      end else begin
        trk_split = '0;
      end
    end else if (stable) begin
      trk_mode   = MODE_NORMAL;
      trk_merged = '0;
      trk_split  = '0;
    end
    trk_last_cnt = cnt;
    trk_last_ovl = ovl;
    res.mode   = trk_mode;
    res.merged = trk_merged;
    res.split  = trk_split;
    res.frozen = (trk_mode == MODE_MERGED) || (trk_mode == MODE_SPLIT) || ovl;
    return res;
  endfunction

  // Offer one frame beat, hold it until taken, then queue its expected result
  task automatic push_frame(input logic [COUNT_W-1:0] cnt, input logic ovl,
                            input logic typed = 1'b0, input frame_result_t given = '0);
    int unsigned   gap;
    frame_result_t want;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_if.valid        <= 1'b1;
    frame_if.person_count <= cnt;
    frame_if.overlap_seen <= ovl;
    do @(posedge clk_i); while (!frame_if.ready);
    want = track_frame(cnt, ovl);
    due_results.push_back(typed ? given : want);
  endtask

  // Raise the register write and hold it until taken; caller lowers valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_OVERLAP_REQ:  cfg_ovl_req = val[0];
      CFG_MERGE_HOLD:   cfg_hold    = val[HOLD_W-1:0];
      CFG_SPLIT_STABLE: cfg_stable  = val[STABLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic ovl_req, input logic [CFG_DATA_W-1:0] hold,
                              input logic [CFG_DATA_W-1:0] stable);
    write_reg(CFG_OVERLAP_REQ, {(CFG_DATA_W-1)'($urandom_range(0, 32767)), ovl_req});
    write_reg(CFG_MERGE_HOLD, hold);
    write_reg(CFG_SPLIT_STABLE, stable);
    // unmapped index must leave every register alone
    write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain();
    frame_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One group-merge-split story with random content, sometimes followed by noise
  task automatic run_episode(inout int unsigned sent);
    int unsigned reps;
    int unsigned hold_eff;
    int unsigned need_eff;
    hold_eff = (cfg_hold == '0) ? 1 : cfg_hold;
    need_eff = (cfg_stable == '0) ? 1 : cfg_stable;
    reps = $urandom_range(1, 3);
    repeat (reps) push_frame(COUNT_W'($urandom_range(2, 15)), 1'($urandom_range(0, 1)));
    sent += reps;
    push_frame(SINGLE_PERSON, cfg_ovl_req ? 1'b1 : 1'($urandom_range(0, 1)));
    sent++;
    reps = $urandom_range(0, ((hold_eff < 20) ? hold_eff : 20) + 1);
    repeat (reps) push_frame(($urandom_range(0, 7) == 0) ? COUNT_W'(0) : SINGLE_PERSON,
                             1'($urandom_range(0, 1)));
    sent += reps;
    reps = $urandom_range(1, ((need_eff < 20) ? need_eff : 20) + 2);
    repeat (reps) push_frame(COUNT_W'($urandom_range(2, 15)), $urandom_range(0, 5) == 0);
    sent += reps;
    if ($urandom_range(0, 3) == 0) begin
      reps = $urandom_range(1, 4);
      repeat (reps) push_frame(COUNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      sent += reps;
    end
  endtask

  task automatic run_phase(input logic ovl_req, input logic [CFG_DATA_W-1:0] hold,
                           input logic [CFG_DATA_W-1:0] stable);
    int unsigned sent;
    sent = 0;
    program_regs(ovl_req, hold, stable);
    while (sent < PHASE_FRAMES) run_episode(sent);
    drain();
  endtask

  // Frame and register stimulus
  initial begin
    rst_ni                = 1'b0;
    frame_if.valid        = 1'b0;
    frame_if.person_count = '0;
    frame_if.overlap_seen = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_OVERLAP_REQ;
    cfg_if.data           = '0;
    errors                = 0;
    results_seen          = 0;
    in_calm               = 0;
    no_idle               = 1'b0;
    reset_tracker();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      push_frame(directed_rows[i].cnt, directed_rows[i].ovl, directed_rows[i].typed,
                 directed_rows[i].want);
    end
    drain();

    // zero holds act as one; then the register extremes with stray upper bits
    run_phase(1'b0, 16'h0000, 16'h0000);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF);
    repeat (6) begin
      run_phase(1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(9, 24))
                                            : CFG_DATA_W'($urandom_range(0, 8)),
                {8'($urandom_range(0, 255)), 8'($urandom_range(0, 8))});
    end

    // stay merged well short of the largest hold, then fall back to normal on groups
    program_regs(1'b0, 16'hFFFF, 16'h0001);
    no_idle = 1'b1;
    push_frame(GROUP_MIN, 1'b0);
    repeat (HOLD_RUN) push_frame(SINGLE_PERSON, 1'($urandom_range(0, 1)));
    push_frame(COUNT_W'(3), 1'b0);
    push_frame(COUNT_W'(5), 1'b0);
    no_idle = 1'b0;
    drain();

    run_phase(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 6)),
              CFG_DATA_W'($urandom_range(0, 6)));

    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result ready with random stalls
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    out_calm     = 0;
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (res_if.lifecycle_mode !== want.mode)
          report_mismatch($sformatf("result %0d mode got %0d want %0d", results_seen,
                                    res_if.lifecycle_mode, want.mode));
        if (res_if.merged_frame_count !== want.merged)
          report_mismatch($sformatf("result %0d merged count got %0d want %0d", results_seen,
                                    res_if.merged_frame_count, want.merged));
        if (res_if.stable_split_count !== want.split)
          report_mismatch($sformatf("result %0d split count got %0d want %0d", results_seen,
                                    res_if.stable_split_count, want.split));
        if (res_if.features_frozen !== want.frozen)
          report_mismatch($sformatf("result %0d frozen got %0d want %0d", results_seen,
                                    res_if.features_frozen, want.frozen));
      end
      results_seen++;
    end
  end

  // Stop the run when no channel moves a beat for too long
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (frame_if.valid && frame_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
sv/omsf_pkg.sv
sv/omsf_if.sv
sv/omsf_cfg_regs.sv
sv/omsf_track.sv
sv/occlusion_merge_split_fsm.sv
sv/omsf_checker.sv
tb/tb_top.sv
